/* rtl/akc_pkg.sv */
package akc_pkg;

  localparam int MAX_WIDTH = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_KERNEL = 5;
  localparam int FRAC = 16;
  localparam int MAX_HALF = MAX_KERNEL / 2;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;

  localparam logic [2:0] EFF_NONE = 3'd0;
  localparam logic [2:0] EFF_BOX = 3'd1;
  localparam logic [2:0] EFF_MOTION = 3'd2;
  localparam logic [2:0] EFF_GAUSS = 3'd3;
  localparam logic [2:0] EFF_LAPLACE = 3'd4;
  localparam logic [2:0] EFF_EDGE = 3'd5;
  localparam logic [2:0] EFF_SHARPEN = 3'd6;
  localparam logic [2:0] EFF_EMBOSS = 3'd7;

  localparam logic [1:0] EDGE_CLAMP = 2'd1;
  localparam logic [1:0] EDGE_WRAP = 2'd2;

  localparam logic [2:0] REG_EFFECT = 3'd0;
  localparam logic [2:0] REG_HALF_COLS = 3'd1;
  localparam logic [2:0] REG_HALF_ROWS = 3'd2;
  localparam logic [2:0] REG_EDGE_MODE = 3'd3;
  localparam logic [2:0] REG_WIDTH = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  // controller -> datapath commands
  typedef struct packed {
    logic       clear;    // start of a compute: clear accumulators
    logic       tap_en;   // current tap valid, read memory
    logic [2:0] r;        // tap row 0..4
    logic [2:0] c;        // tap col 0..4
    logic       acc_en;   // accumulate the word read last cycle
    logic       fin;      // compute scaled result
    logic       pass;     // latch raw memory word as result
    logic       zero;     // result is zero
  } akc_cmd_t;

  // kernel weight, -1..9
  function automatic logic signed [4:0] kern_weight(input logic [2:0] eff,
                                                    input logic [2:0] r,
                                                    input logic [2:0] c);
    logic signed [4:0] w;
    w = 5'sd0;
    unique case (eff)
      EFF_BOX: w = 5'sd1;
      EFF_MOTION: w = (r == c) ? 5'sd1 : 5'sd0;
      EFF_GAUSS: w = (r == 3'd1 && c == 3'd1) ? 5'sd4 :
                     ((r == 3'd1 || c == 3'd1) ? 5'sd2 : 5'sd1);
      EFF_EMBOSS: w = (r + c < 3'd2) ? -5'sd1 : ((r + c == 3'd2) ? 5'sd0 : 5'sd1);
      EFF_SHARPEN: w = (r == 3'd1 && c == 3'd1) ? 5'sd9 : -5'sd1;
      default: w = (r == 3'd1 && c == 3'd1) ? 5'sd8 : -5'sd1;
    endcase
    return w;
  endfunction

  // round-half-up of 2^FRAC / div
  function automatic logic [FRAC:0] scale_of(input logic [4:0] div);
    logic [FRAC:0] s;
    s = (FRAC+1)'(1 << FRAC);
    unique case (div)
      5'd1: s = (FRAC+1)'(1 << FRAC);
      5'd3: s = (FRAC+1)'(((1 << FRAC) + 1) / 3);
      5'd5: s = (FRAC+1)'(((1 << FRAC) + 2) / 5);
      5'd8: s = (FRAC+1)'(((1 << FRAC) + 4) / 8);
      5'd9: s = (FRAC+1)'(((1 << FRAC) + 4) / 9);
      5'd15: s = (FRAC+1)'(((1 << FRAC) + 7) / 15);
      5'd16: s = (FRAC+1)'(((1 << FRAC) + 8) / 16);
      5'd25: s = (FRAC+1)'(((1 << FRAC) + 12) / 25);
      default: s = (FRAC+1)'(1 << FRAC);
    endcase
    return s;
  endfunction

endpackage

/* rtl/argb_kernel_convolution_top.sv */
// ARGB 3x3/5x5 convolution over a 256x256 frame store.
// Input channel (in_valid/in_stall): operation 0 writes pixel_in at
// (pos_x,pos_y), no result; operation 1 computes one filtered pixel.
// Output channel (out_valid/out_stall): one out_pixel beat per compute.
// Config channel (cfg_valid/cfg_ready): index 0..5 = effect, box half cols,
// box half rows, edge mode, width, height; write only while idle.
// Write: taken every cycle while no compute is in flight. Filtered compute:
// one frame-store read per kernel tap on the single port memory, N = 1
// (1x1 box) to 25 (5x5) taps. Pass-through: the pixel is read at accept
// and latched as the result; out-of-frame: the result is zero.
// One compute in flight at a time.
// Results sit in an output register; while out_stall is high the block
// holds the beat and takes no new input beat.
// Reset (rst, synchronous): registers to their defaults (effect none, box
// 3x3, zero edges, 256x256); the frame store is not cleared.
module argb_kernel_convolution_top
  import akc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [31:0] pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [2:0] effect;
  logic [1:0] box_half_cols, box_half_rows, edge_mode;
  logic [8:0] image_width, image_height, w_eff, h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect <= EFF_NONE;
      box_half_cols <= 2'd1;
      box_half_rows <= 2'd1;
      edge_mode <= '0;
      image_width <= 9'(MAX_WIDTH);
      image_height <= 9'(MAX_HEIGHT);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EFFECT: effect <= cfg_data[2:0];
        REG_HALF_COLS: box_half_cols <= cfg_data[1:0];
        REG_HALF_ROWS: box_half_rows <= cfg_data[1:0];
        REG_EDGE_MODE: edge_mode <= cfg_data[1:0];
        REG_WIDTH: image_width <= cfg_data[8:0];
        REG_HEIGHT: image_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // zero size acts as one, oversize as max
  assign w_eff = (image_width == '0) ? 9'd1 :
                 (image_width > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : image_width;
  assign h_eff = (image_height == '0) ? 9'd1 :
                 (image_height > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : image_height;

  logic busy;
  logic in_fire;
  akc_cmd_t cmd;

  assign in_stall = busy;
  assign in_fire = in_valid && !busy;

  // output register
  logic out_free;
  assign out_free = !out_stall;
  logic hold_q;
  always_ff @(posedge clk) begin
    if (rst) hold_q <= 1'b0;
    else if (cmd.zero || cmd.pass || cmd.fin) hold_q <= 1'b1;
    else if (out_valid && !out_stall) hold_q <= 1'b0;
  end
  assign out_valid = hold_q;

  akc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .operation(operation),
    .pos_x(pos_x), .pos_y(pos_y), .effect(effect),
    .box_half_cols(box_half_cols), .box_half_rows(box_half_rows),
    .w_eff(w_eff), .h_eff(h_eff), .out_free(hold_q && out_free),
    .busy(busy), .cmd(cmd)
  );

  akc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .wr_en(in_fire && !operation), .rd_now(in_fire && operation && !cmd.clear),
    .pos_x(pos_x), .pos_y(pos_y), .pixel_in(pixel_in), .effect(effect),
    .box_half_cols(box_half_cols), .box_half_rows(box_half_rows),
    .edge_mode(edge_mode), .w_eff(w_eff), .h_eff(h_eff), .result(out_pixel)
  );

endmodule

/* rtl/akc_ctrl.sv */
module akc_ctrl
  import akc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic       operation,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [2:0] effect,
  input  logic [1:0] box_half_cols,
  input  logic [1:0] box_half_rows,
  input  logic [8:0] w_eff,
  input  logic [8:0] h_eff,
  input  logic       out_free,
  output logic       busy,
  output akc_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAP = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_FIN = 3'd3;
  localparam logic [2:0] S_PASS = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] r, c;
  logic [1:0] hr, hc;
  logic [1:0] hb_c, hb_r;

  assign hb_c = (box_half_cols > 2'(MAX_HALF)) ? 2'(MAX_HALF) : box_half_cols;
  assign hb_r = (box_half_rows > 2'(MAX_HALF)) ? 2'(MAX_HALF) : box_half_rows;

  logic [2:0] kmax_r, kmax_c;
  assign kmax_r = {hr, 1'b0};
  assign kmax_c = {hc, 1'b0};

  logic compute_go;
  assign compute_go = in_fire && operation;

  logic outside;
  assign outside = ({1'b0, pos_x} >= w_eff) || ({1'b0, pos_y} >= h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r <= '0;
      c <= '0;
      hr <= 2'd1;
      hc <= 2'd1;
    end else begin
      state <= state_next;
      if (state == S_IDLE && compute_go) begin
        r <= '0;
        c <= '0;
        if (effect == EFF_BOX) begin
          hr <= hb_r;
          hc <= hb_c;
        end else if (effect == EFF_MOTION) begin
          hr <= 2'd2;
          hc <= 2'd2;
        end else begin
          hr <= 2'd1;
          hc <= 2'd1;
        end
      end else if (state == S_TAP) begin
        if (c == kmax_c) begin
          c <= '0;
          r <= r + 3'd1;
        end else begin
          c <= c + 3'd1;
        end
      end
    end
  end

  logic last_tap;
  assign last_tap = (r == kmax_r) && (c == kmax_c);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.r = r;
    cmd.c = c;
    unique case (state)
      S_IDLE: begin
        if (compute_go) begin
          if (outside) begin
            cmd.zero = 1'b1;
            state_next = S_HOLD;
          end else if (effect == EFF_NONE) begin
            state_next = S_PASS;
          end else begin
            cmd.clear = 1'b1;
            state_next = S_TAP;
          end
        end
      end
      S_TAP: begin
        cmd.tap_en = 1'b1;
        if (last_tap) state_next = S_LAST;
      end
      S_LAST: begin
        cmd.acc_en = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_next = S_HOLD;
      end
      S_PASS: begin
        cmd.pass = 1'b1;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // accumulate previous tap's read while stepping
    if (state == S_TAP && !(r == 3'd0 && c == 3'd0)) cmd.acc_en = 1'b1;
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/akc_datapath.sv */
module akc_datapath
  import akc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  akc_cmd_t    cmd,
  input  logic        wr_en,
  input  logic        rd_now,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [31:0] pixel_in,
  input  logic [2:0]  effect,
  input  logic [1:0]  box_half_cols,
  input  logic [1:0]  box_half_rows,
  input  logic [1:0]  edge_mode,
  input  logic [8:0]  w_eff,
  input  logic [8:0]  h_eff,
  output logic [31:0] result
);

  logic [31:0] mem [MAX_WIDTH*MAX_HEIGHT];
  logic [31:0] rd_data;

  logic [7:0] cx, cy;
  logic [1:0] hr, hc;
  logic [2:0] eff;

  always_ff @(posedge clk) begin
    if (cmd.clear || rd_now) begin
      cx <= pos_x;
      cy <= pos_y;
    end
    if (cmd.clear) begin
      eff <= effect;
      if (effect == EFF_BOX) begin
        hc <= (box_half_cols > 2'(MAX_HALF)) ? 2'(MAX_HALF) : box_half_cols;
        hr <= (box_half_rows > 2'(MAX_HALF)) ? 2'(MAX_HALF) : box_half_rows;
      end else if (effect == EFF_MOTION) begin
        hc <= 2'd2;
        hr <= 2'd2;
      end else begin
        hc <= 2'd1;
        hr <= 2'd1;
      end
    end
  end

  // tap coordinate
  logic signed [10:0] ty, tx;
  logic [7:0] ay, ax;
  logic skip;
  logic signed [4:0] wt;

  // wrap: a one-wide or one-high frame always maps to index 0
  always_comb begin
    ty = $signed({3'b0, cy}) + $signed({8'b0, cmd.r}) - $signed({9'b0, hr});
    tx = $signed({3'b0, cx}) + $signed({8'b0, cmd.c}) - $signed({9'b0, hc});
    skip = 1'b0;
    ay = ty[7:0];
    ax = tx[7:0];
    if (ty < 0 || ty >= $signed({2'b0, h_eff})) begin
      if (edge_mode == EDGE_CLAMP) ay = cy;
      else if (edge_mode == EDGE_WRAP) begin
        if (h_eff == 9'd1) ay = 8'd0;
        else ay = (ty < 0) ? 8'(ty + $signed({2'b0, h_eff})) :
                             8'(ty - $signed({2'b0, h_eff}));
      end
      else skip = 1'b1;
    end
    if (tx < 0 || tx >= $signed({2'b0, w_eff})) begin
      if (edge_mode == EDGE_CLAMP) ax = cx;
      else if (edge_mode == EDGE_WRAP) begin
        if (w_eff == 9'd1) ax = 8'd0;
        else ax = (tx < 0) ? 8'(tx + $signed({2'b0, w_eff})) :
                             8'(tx - $signed({2'b0, w_eff}));
      end
      else skip = 1'b1;
    end
    wt = kern_weight(eff, cmd.r, cmd.c);
  end

  logic [AW-1:0] rd_addr;
  assign rd_addr = rd_now ? {pos_y, pos_x} : {ay, ax};

  always_ff @(posedge clk) begin
    if (wr_en) mem[{pos_y, pos_x}] <= pixel_in;
    rd_data <= mem[rd_addr];
  end

  // weight travelling alongside read
  logic signed [4:0] wt_d;
  always_ff @(posedge clk) begin
    if (rst) wt_d <= '0;
    else wt_d <= (cmd.tap_en && !skip) ? wt : 5'sd0;
  end

  logic signed [13:0] acc [4];
  logic [4:0] div;
  logic [FRAC:0] scale;
  always_comb begin
    unique case (eff)
      EFF_BOX: div = 5'(({3'b0, hc} * 5'd2 + 5'd1) * ({3'b0, hr} * 5'd2 + 5'd1));
      EFF_MOTION: div = 5'd5;
      EFF_GAUSS: div = 5'd16;
      EFF_LAPLACE: div = 5'd8;
      default: div = 5'd1;
    endcase
    scale = scale_of(div);
  end

  logic signed [FRAC+17:0] v [4];
  logic [7:0] q [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      v[k] = (FRAC+18)'(acc[k]) * $signed({1'b0, scale})
           + ((eff == EFF_EMBOSS) ? (FRAC+18)'(128 << FRAC) : '0)
           + (FRAC+18)'(1 << (FRAC-1));
      if (v[k] < 0) q[k] = 8'd0;
      else if (v[k][FRAC+17:FRAC] > 255) q[k] = 8'd255;
      else q[k] = v[k][FRAC+7:FRAC];
    end
  end

  // zero-weight and dropped taps never touch the sums
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (cmd.clear) acc[k] <= '0;
      else if (cmd.acc_en && wt_d != 5'sd0)
        acc[k] <= acc[k] + 14'(wt_d * $signed({1'b0, rd_data[8*k +: 8]}));
    end
    if (cmd.zero) result <= '0;
    else if (cmd.pass) result <= rd_data;
    else if (cmd.fin) result <= {q[3], q[2], q[1], q[0]};
  end

endmodule
